// ----- src/ipu_pkg.sv -----
// Package for the integer pixel upscaler: field widths, item kinds, register
// indexes and the reciprocal table used to divide an output column by the scale.
// No dependencies.
`default_nettype none

package ipu_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int PIX_W      = 24;
  localparam int SCALE_W    = 4;
  localparam int RWIDTH_W   = 11;
  localparam int POS_W      = 14;
  localparam int PAD_W      = 2;
  localparam int MAX_SCALE  = 9;
  localparam int RECIP_SH   = 18;
  localparam int RECIP_W    = RECIP_SH + 1;
  localparam int PROD_W     = POS_W + RECIP_W;

  typedef enum logic {
    MODE_PUSH  = 1'b0,
    MODE_DRAIN = 1'b1
  } mode_t;

  typedef enum logic {
    CFG_SCALE = 1'b0,
    CFG_WIDTH = 1'b1
  } cfg_idx_t;

  // ceil(2^18 / s) for s from 2 to 9, 2^18 for any other s; exact floor division for every column below 2^14.
  function automatic logic [RECIP_W-1:0] ipu_recip(input logic [SCALE_W-1:0] s);
    logic [RECIP_W-1:0] r;
    unique case (s)
      4'd2:    r = 19'd131072;
      4'd3:    r = 19'd87382;
      4'd4:    r = 19'd65536;
      4'd5:    r = 19'd52429;
      4'd6:    r = 19'd43691;
      4'd7:    r = 19'd37450;
      4'd8:    r = 19'd32768;
      4'd9:    r = 19'd29128;
      default: r = 19'd262144;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/ipu_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module ipu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire  logic                     clk,
  input  wire  logic                     we,
  input  wire  logic [$clog2(DEPTH)-1:0] waddr,
  input  wire  logic [WIDTH-1:0]         wdata,
  input  wire  logic                     re,
  input  wire  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/integer_pixel_upscaler_top.sv -----
// Top level of the nearest-neighbor integer upscaler.
// Uses ipu_pkg and one ipu_ram instance as the line store.
//
//   port group  dir  contents
//   in_*        in   tdata = pixel[23:0], tuser = mode
//   out_*       out  tdata = out_pixel[23:0], tlast = row_end, tuser = pad_bytes, last
//   cfg_*       in   write enable, register index, write data
//
// A push item gives scale_factor results (1 to 9) on consecutive cycles, a drain item one,
// while the output is not stalled. The copy counter of the emit stage sets that figure; the
// first result of an item passes the p1 stage, the emit stage and the output register to out_tvalid.
// Reset is synchronous and clears the control state only; the line store is not cleared.
// Stalls on the output hold the emit stage and, behind it, the input.
`default_nettype none

module integer_pixel_upscaler_top
  import ipu_pkg::*;
(
  input  wire  logic                clk,
  input  wire  logic                rst_n,
  input  wire  logic                in_tvalid,
  output logic                      in_tready,
  input  wire  logic [PIX_W-1:0]    in_tdata,   // pixel[23:0]
  input  wire  logic [0:0]          in_tuser,   // mode[0]
  output logic                      out_tvalid,
  input  wire  logic                out_tready,
  output logic [PIX_W-1:0]          out_tdata,  // out_pixel[23:0]
  output logic                      out_tlast,
  output logic [PAD_W:0]            out_tuser,  // pad_bytes[1:0], last[2]
  input  wire  logic                cfg_we,
  input  wire  logic                cfg_index,
  input  wire  logic [RWIDTH_W-1:0] cfg_wdata
);

  logic [SCALE_W-1:0]  scale_r;
  logic [RWIDTH_W-1:0] rwidth_r;
  logic [COL_W-1:0]    in_column_r, in_column_nxt;
  logic [SCALE_W-1:0]  rows_left_r, rows_left_nxt;
  logic [POS_W-1:0]    replay_pos_r, replay_pos_nxt;

  logic [SCALE_W-1:0]  s_eff;
  logic [RWIDTH_W-1:0] w_eff;
  logic [COL_W-1:0]    wm1;
  logic [POS_W-1:0]    ow, owm1;
  mode_t               in_mode;
  logic                in_acc, push_ok, drain_ok, take;
  logic                acc_end;
  logic [POS_W-1:0]    acc_addr;

  logic                p1_valid_r;
  mode_t               p1_mode_r;
  logic [POS_W-1:0]    p1_addr_r;
  logic [SCALE_W-1:0]  p1_scale_r;
  logic [COL_W-1:0]    p1_wm1_r;
  logic [PIX_W-1:0]    p1_pix_r;
  logic                p1_end_r;
  logic [PAD_W-1:0]    p1_pad_r;
  logic                p1_move;
  logic [PROD_W-1:0]   prod;
  logic [POS_W-1:0]    quo;
  logic [COL_W-1:0]    rd_idx;

  logic                p2_valid_r;
  mode_t               p2_mode_r;
  logic [SCALE_W-1:0]  p2_scale_r;
  logic [PIX_W-1:0]    p2_pix_r;
  logic                p2_end_r;
  logic [PAD_W-1:0]    p2_pad_r;
  logic [SCALE_W-1:0]  p2_cnt_r;
  logic                p2_emit, p2_done, p2_lastk;
  logic                out_load;

  logic                ram_we, ram_re;
  logic [COL_W-1:0]    ram_addr;
  logic [PIX_W-1:0]    ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SCALE_W'(1);
      rwidth_r <= RWIDTH_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SCALE: scale_r  <= cfg_wdata[SCALE_W-1:0];
        CFG_WIDTH: rwidth_r <= cfg_wdata;
      endcase
    end
  end

  always_comb begin
    if (scale_r == '0) begin
      s_eff = SCALE_W'(1);
    end else if (scale_r > SCALE_W'(MAX_SCALE)) begin
      s_eff = SCALE_W'(MAX_SCALE);
    end else begin
      s_eff = scale_r;
    end
    if (rwidth_r == '0) begin
      w_eff = RWIDTH_W'(1);
    end else if (rwidth_r > RWIDTH_W'(MAX_WIDTH)) begin
      w_eff = RWIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = rwidth_r;
    end
  end

  assign wm1  = COL_W'(w_eff - RWIDTH_W'(1));
  assign ow   = POS_W'(w_eff) * POS_W'(s_eff);
  assign owm1 = ow - POS_W'(1);

  assign in_mode   = mode_t'(in_tuser[0]);
  assign in_tready = !p1_valid_r || p1_move;
  assign in_acc    = in_tvalid && in_tready;
  assign push_ok   = (in_mode == MODE_PUSH) && (rows_left_r == '0);
  assign drain_ok  = (in_mode == MODE_DRAIN) && (rows_left_r != '0);
  assign take      = in_acc && (push_ok || drain_ok);

  always_comb begin
    in_column_nxt  = in_column_r;
    rows_left_nxt  = rows_left_r;
    replay_pos_nxt = replay_pos_r;
    acc_end        = 1'b0;
    acc_addr       = '0;
    if (push_ok) begin
      acc_end  = (in_column_r >= wm1);
      acc_addr = acc_end ? POS_W'(wm1) : POS_W'(in_column_r);
      if (acc_end) begin
        in_column_nxt  = '0;
        rows_left_nxt  = s_eff - SCALE_W'(1);
        replay_pos_nxt = '0;
      end else begin
        in_column_nxt = in_column_r + COL_W'(1);
      end
    end else if (drain_ok) begin
      acc_end  = (replay_pos_r >= owm1);
      acc_addr = acc_end ? owm1 : replay_pos_r;
      if (acc_end) begin
        replay_pos_nxt = '0;
        rows_left_nxt  = rows_left_r - SCALE_W'(1);
      end else begin
        replay_pos_nxt = replay_pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_column_r  <= '0;
      rows_left_r  <= '0;
      replay_pos_r <= '0;
    end else if (take) begin
      in_column_r  <= in_column_nxt;
      rows_left_r  <= rows_left_nxt;
      replay_pos_r <= replay_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (in_tready) begin
      p1_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      p1_mode_r  <= in_mode;
      p1_addr_r  <= acc_addr;
      p1_scale_r <= s_eff;
      p1_wm1_r   <= wm1;
      p1_pix_r   <= in_tdata;
      p1_end_r   <= acc_end;
      p1_pad_r   <= ow[PAD_W-1:0];
    end
  end

  assign prod   = PROD_W'(p1_addr_r) * PROD_W'(ipu_recip(p1_scale_r));
  assign quo    = prod[RECIP_SH +: POS_W];
  assign rd_idx = (quo > POS_W'(p1_wm1_r)) ? p1_wm1_r : quo[COL_W-1:0];

  assign p1_move  = p1_valid_r && (!p2_valid_r || p2_done);
  assign ram_we   = p1_move && (p1_mode_r == MODE_PUSH);
  assign ram_re   = p1_move && (p1_mode_r == MODE_DRAIN);
  assign ram_addr = (p1_mode_r == MODE_DRAIN) ? rd_idx : p1_addr_r[COL_W-1:0];

  ipu_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (p1_pix_r),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  assign out_load = !out_tvalid || out_tready;
  assign p2_emit  = p2_valid_r && out_load;
  assign p2_lastk = (p2_mode_r == MODE_DRAIN) || (p2_cnt_r == p2_scale_r - SCALE_W'(1));
  assign p2_done  = p2_emit && p2_lastk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_valid_r <= 1'b0;
      p2_cnt_r   <= '0;
    end else if (p1_move) begin
      p2_valid_r <= 1'b1;
      p2_cnt_r   <= '0;
    end else if (p2_done) begin
      p2_valid_r <= 1'b0;
      p2_cnt_r   <= '0;
    end else if (p2_emit) begin
      p2_cnt_r <= p2_cnt_r + SCALE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (p1_move) begin
      p2_mode_r  <= p1_mode_r;
      p2_scale_r <= p1_scale_r;
      p2_pix_r   <= p1_pix_r;
      p2_end_r   <= p1_end_r;
      p2_pad_r   <= p1_pad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (out_load) begin
      out_tvalid <= p2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_emit) begin
      out_tdata <= (p2_mode_r == MODE_DRAIN) ? ram_rdata : p2_pix_r;
      out_tlast <= p2_end_r && p2_lastk;
      out_tuser <= {p2_lastk, (p2_end_r && p2_lastk) ? p2_pad_r : PAD_W'(0)};
    end
  end

  a_ignored_push_dropped : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_mode == MODE_PUSH) && (rows_left_r != '0)) |=> !p1_valid_r)
    else $error("ignored push entered the pipeline");

  a_copy_bound : assert property (@(posedge clk) disable iff (!rst_n)
    p2_valid_r |-> (p2_cnt_r < p2_scale_r))
    else $error("copy counter ran past the scale factor");

  a_ram_one_access : assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("line store read and written in one cycle");

  a_rows_bound : assert property (@(posedge clk) disable iff (!rst_n)
    rows_left_r < SCALE_W'(MAX_SCALE))
    else $error("replay row count out of range");

  a_stall_holds_p2 : assert property (@(posedge clk) disable iff (!rst_n)
    (p2_valid_r && !out_load) |=> (p2_valid_r && $stable(p2_cnt_r)))
    else $error("emit stage advanced while the output was stalled");

endmodule

`default_nettype wire

// ----- test/tb_integer_pixel_upscaler_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for integer_pixel_upscaler_top: a scoreboard class predicts
// every upscaled pixel from the accepted input items and checks the output stream.
// Depends on ipu_pkg and the upscaler RTL only.

module tb_integer_pixel_upscaler_top
  import ipu_pkg::*;
();

  localparam int SETTLE       = 16;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 480;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             row_end;
    logic [PAD_W-1:0] pad;
    logic             last;
  } upscaled_px_t;

  class upscale_scoreboard;
    logic [PIX_W-1:0] line_copy [MAX_WIDTH];
    bit               written [MAX_WIDTH];
    int unsigned      column, rows_left, position, scale_reg, width_reg;
    bit               row_closed;
    int               errors;
    upscaled_px_t     pending_pixels [$];

    function new();
      column = 0;
      rows_left = 0;
      position = 0;
      scale_reg = 1;
      width_reg = 1;
      row_closed = 0;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [RWIDTH_W-1:0] v);
      if (idx == CFG_SCALE) begin
        scale_reg = v[SCALE_W-1:0];
      end else begin
        width_reg = v;
      end
    endfunction

    function int unsigned eff_scale();
      if (scale_reg < 1) return 1;
      if (scale_reg > MAX_SCALE) return MAX_SCALE;
      return scale_reg;
    endfunction

    function int unsigned eff_width();
      if (width_reg < 1) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    // Number of consecutive line store entries, counted from column zero, that hold a pixel.
    function int unsigned filled_span();
      int unsigned n;
      n = 0;
      while (n < MAX_WIDTH && written[n]) n++;
      return n;
    endfunction

    function int note_input(mode_t m, logic [PIX_W-1:0] px);
      int unsigned  s, w, ow, col, pos, idx;
      logic [PAD_W-1:0] pad;
      bit           done_row;
      upscaled_px_t r;
      s = eff_scale();
      w = eff_width();
      ow = w * s;
      pad = PAD_W'(ow % 4);
      if (m == MODE_PUSH) begin
        if (rows_left != 0) return 0;
        col = (column > w - 1) ? w - 1 : column;
        line_copy[col] = px;
        written[col] = 1;
        done_row = (column >= w - 1);
        for (int k = 0; k < s; k++) begin
          r.pix = px;
          r.last = (k == s - 1);
          r.row_end = done_row && r.last;
          r.pad = r.row_end ? pad : '0;
          pending_pixels.push_back(r);
        end
        if (done_row) begin
          column = 0;
          rows_left = s - 1;
          position = 0;
          row_closed = 1;
        end else begin
          column = (column + 1) & 'h3FF;
        end
        return s;
      end
      if (rows_left == 0) return 0;
      pos = position;
      done_row = (pos >= ow - 1);
      if (pos > ow - 1) pos = ow - 1;
      idx = pos / s;
      if (idx > w - 1) idx = w - 1;
      r.pix = line_copy[idx];
      r.row_end = done_row;
      r.pad = done_row ? pad : '0;
      r.last = 1'b1;
      pending_pixels.push_back(r);
      if (done_row) begin
        position = 0;
        rows_left = (rows_left - 1) & 'hF;
      end else begin
        position = (position + 1) & 'h3FFF;
      end
      return 1;
    endfunction

    function void check_result(logic [PIX_W-1:0] pix, logic row_end, logic [PAD_W:0] user);
      upscaled_px_t got, want;
      got.pix = pix;
      got.row_end = row_end;
      got.pad = user[PAD_W-1:0];
      got.last = user[PAD_W];
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual pix %h end %b pad %0d last %b",
                 $time, got.pix, got.row_end, got.pad, got.last);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      if (got.pix !== want.pix || got.row_end !== want.row_end ||
          got.pad !== want.pad || got.last !== want.last) begin
        $display("%0t: mismatch, expected pix %h end %b pad %0d last %b, actual pix %h end %b pad %0d last %b",
                 $time, want.pix, want.row_end, want.pad, want.last,
                 got.pix, got.row_end, got.pad, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [PIX_W-1:0]    in_tdata = '0;   // pixel[23:0]
  logic [0:0]          in_tuser = '0;   // mode[0]
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [PIX_W-1:0]    out_tdata;       // out_pixel[23:0]
  logic                out_tlast;
  logic [PAD_W:0]      out_tuser;       // pad_bytes[1:0], last[2]
  logic                cfg_we = 1'b0;
  logic                cfg_index = 1'b0;
  logic [RWIDTH_W-1:0] cfg_wdata = '0;

  upscale_scoreboard sb = new();
  int productive = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit send_calm = 0;
  bit rdy_calm = 0;

  integer_pixel_upscaler_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: check each accepted item, then pick the next ready value.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tlast, out_tuser);
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if ($urandom_range(0, 255) == 0) begin
      rdy_calm <= ~rdy_calm;
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (rdy_calm || $urandom_range(0, 99) < 70) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 2);
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (send_calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  task automatic send_item(input mode_t m, input logic [PIX_W-1:0] px);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= m;
    in_tdata <= px;
    do @(posedge clk); while (!in_tready);
    if (sb.note_input(m, px) > 0) productive++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(input logic [RWIDTH_W-1:0] scale_v, input logic [RWIDTH_W-1:0] width_v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= CFG_SCALE;
    cfg_wdata <= scale_v;
    @(posedge clk);
    sb.set_reg(CFG_SCALE, scale_v);
    cfg_index <= CFG_WIDTH;
    cfg_wdata <= width_v;
    @(posedge clk);
    sb.set_reg(CFG_WIDTH, width_v);
    cfg_we <= 1'b0;
  endtask

  // Sends whole rows with their replica rows; noise items and register changes are mixed in.
  task automatic run_rows(input int nrows, input int noise_pct, input int cfg_pct);
    int    done;
    int    span;
    mode_t m;
    done = 0;
    sb.row_closed = 0;
    while (done < nrows) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        m = mode_t'($urandom_range(0, 1));
      end else begin
        m = (sb.rows_left != 0) ? MODE_DRAIN : MODE_PUSH;
      end
      send_item(m, PIX_W'($urandom));
      if (sb.row_closed && sb.rows_left == 0) begin
        done++;
        sb.row_closed = 0;
      end
      if ($urandom_range(0, 99) < cfg_pct) begin
        span = sb.filled_span();
        if (span > 8) span = 8;
        write_regs(RWIDTH_W'($urandom_range(0, 15)),
                   RWIDTH_W'((sb.rows_left != 0) ? $urandom_range(1, span)
                                                 : $urandom_range(1, 8)));
      end else if ($urandom_range(0, 99) < 2) begin
        wait_drained();
      end
    end
  endtask

  initial begin
    int s_v, w_v, es, r;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(MODE_DRAIN, 24'hA5A5A5);
    send_item(MODE_PUSH, 24'h000000);
    write_regs(0, 0);
    send_item(MODE_PUSH, 24'hFFFFFF);
    write_regs(3, 2);
    send_item(MODE_PUSH, PIX_W'($urandom));
    send_item(MODE_PUSH, PIX_W'($urandom));
    send_item(MODE_PUSH, PIX_W'($urandom));
    repeat (3) send_item(MODE_DRAIN, PIX_W'($urandom));
    write_regs(2, 1);
    repeat (3) send_item(MODE_DRAIN, PIX_W'($urandom));
    write_regs(1, 4);
    repeat (2) send_item(MODE_PUSH, PIX_W'($urandom));
    write_regs(1, 2);
    send_item(MODE_PUSH, PIX_W'($urandom));

    send_calm = 1;
    write_regs(2, 2047);
    run_rows(1, 0, 0);

    productive = 0;
    while (productive < RANDOM_ITEMS) begin
      send_calm = ($urandom_range(0, 3) == 0);
      s_v = ($urandom_range(0, 99) < 15) ? (($urandom_range(0, 6) == 0) ? 0 : $urandom_range(10, 15))
                                         : $urandom_range(1, 9);
      es = (s_v == 0) ? 1 : ((s_v > MAX_SCALE) ? MAX_SCALE : s_v);
      r = $urandom_range(0, 9);
      if (r == 0) begin
        w_v = 0;
      end else if (r == 1 && es <= 2) begin
        w_v = $urandom_range(9, 24);
      end else begin
        w_v = (es >= 6) ? $urandom_range(1, 3) : $urandom_range(1, 8);
      end
      write_regs(RWIDTH_W'(s_v), RWIDTH_W'(w_v));
      run_rows($urandom_range(1, 3), 10, 3);
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/ipu_pkg.sv
src/ipu_ram.sv
src/integer_pixel_upscaler_top.sv
test/tb_integer_pixel_upscaler_top.sv
